@@ sv/udsd_pkg.sv @@
// Shared types, constants and the script classifier for the UTF-8 decoder.
package udsd_pkg;

  localparam int OFFSET_BITS  = 16;
  localparam int CODE_BITS    = 21;
  localparam int CMD_DEPTH    = 4;
  localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
  localparam int RES_DEPTH    = 2;

  localparam logic [CODE_BITS-1:0] REPL_CHAR = 21'h00FFFD;

  // action that ends a command word
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_CHAR = 2'd1;
  localparam logic [1:0] ACT_REPL = 2'd2;
  localparam logic [1:0] ACT_SUM  = 2'd3;

  localparam logic [3:0] SCR_COMMON   = 4'd0;
  localparam logic [3:0] SCR_HAN      = 4'd1;
  localparam logic [3:0] SCR_LATIN    = 4'd2;
  localparam logic [3:0] SCR_HIRAGANA = 4'd3;
  localparam logic [3:0] SCR_KATAKANA = 4'd4;
  localparam logic [3:0] SCR_HANGUL   = 4'd5;
  localparam logic [3:0] SCR_ARABIC   = 4'd6;
  localparam logic [3:0] SCR_HEBREW   = 4'd7;
  localparam logic [3:0] SCR_THAI     = 4'd8;

  // one decoded byte's worth of work: replacements to flush, then one action
  typedef struct packed {
    logic [1:0]             n_flush;
    logic [OFFSET_BITS-1:0] flush_off;
    logic [1:0]             act;
    logic [CODE_BITS-1:0]   cp;
    logic [2:0]             len;
    logic [OFFSET_BITS-1:0] off;
  } cmd_t;

  typedef struct packed {
    logic                   kind;
    logic [CODE_BITS-1:0]   code_point;
    logic [2:0]             byte_length;
    logic [15:0]            byte_offset;
    logic                   replaced;
    logic [3:0]             script_class;
    logic                   last_of_run;
  } res_t;

  function automatic logic [3:0] classify(input logic [CODE_BITS-1:0] cp);
    logic [3:0] cls;
    begin
      priority if ((cp >= 21'h4E00  && cp <= 21'h9FFF)  || (cp >= 21'h3400  && cp <= 21'h4DBF) ||
                   (cp >= 21'h20000 && cp <= 21'h2A6DF) || (cp >= 21'h2A700 && cp <= 21'h2B73F) ||
                   (cp >= 21'h2B740 && cp <= 21'h2B81F) || (cp >= 21'hF900  && cp <= 21'hFAFF) ||
                   (cp >= 21'h2F800 && cp <= 21'h2FA1F)) begin
        cls = SCR_HAN;
      end else if ((cp >= 21'h20 && cp <= 21'h7F) || (cp >= 21'hA0 && cp <= 21'h24F)) begin
        cls = SCR_LATIN;
      end else if (cp >= 21'h3040 && cp <= 21'h309F) begin
        cls = SCR_HIRAGANA;
      end else if (cp >= 21'h30A0 && cp <= 21'h30FF) begin
        cls = SCR_KATAKANA;
      end else if (cp >= 21'hAC00 && cp <= 21'hD7AF) begin
        cls = SCR_HANGUL;
      end else if (cp >= 21'h0600 && cp <= 21'h06FF) begin
        cls = SCR_ARABIC;
      end else if (cp >= 21'h0590 && cp <= 21'h05FF) begin
        cls = SCR_HEBREW;
      end else if (cp >= 21'h0E00 && cp <= 21'h0E7F) begin
        cls = SCR_THAI;
      end else begin
        cls = SCR_COMMON;
      end
      return cls;
    end
  endfunction

endpackage

@@ sv/udsd_front.sv @@
// Front end: UTF-8 sequence tracking, turns each byte into a command word.
module udsd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          text_byte,
  output logic                cmd_push,
  output udsd_pkg::cmd_t      cmd
);

  logic [1:0]                       bytes_expected, bytes_expected_next;
  logic [1:0]                       bytes_taken, bytes_taken_next;
  logic [udsd_pkg::CODE_BITS-1:0]   partial_code, partial_code_next;
  logic [udsd_pkg::OFFSET_BITS-1:0] sequence_start, sequence_start_next;
  logic [udsd_pkg::OFFSET_BITS-1:0] next_offset, next_offset_next;

  logic                           is_cont;
  logic                           pending;
  logic [1:0]                     flush_cnt;
  logic [udsd_pkg::CODE_BITS-1:0] gathered;
  logic [2:0]                     taken_inc;

  assign is_cont   = (text_byte[7:6] == 2'b10);
  assign pending   = (bytes_expected != 2'd0);
  assign flush_cnt = pending ? bytes_taken + 2'd1 : 2'd0;
  assign gathered  = {partial_code[udsd_pkg::CODE_BITS-7:0], text_byte[5:0]};
  assign taken_inc = {1'b0, bytes_taken} + 3'd1;

  always_comb begin
    bytes_expected_next = bytes_expected;
    bytes_taken_next    = bytes_taken;
    partial_code_next   = partial_code;
    sequence_start_next = sequence_start;
    next_offset_next    = next_offset + 1'b1;
    cmd           = '0;
    cmd.flush_off = sequence_start;
    cmd.act       = udsd_pkg::ACT_NONE;
    priority if (text_byte == 8'h00) begin
      cmd.n_flush         = flush_cnt;
      cmd.act             = udsd_pkg::ACT_SUM;
      cmd.off             = next_offset;
      bytes_expected_next = 2'd0;
      bytes_taken_next    = 2'd0;
      partial_code_next   = '0;
      sequence_start_next = '0;
      next_offset_next    = '0;
    end else if (pending && is_cont) begin
      if (taken_inc >= {1'b0, bytes_expected}) begin
        cmd.act             = udsd_pkg::ACT_CHAR;
        cmd.cp              = gathered;
        cmd.len             = {1'b0, bytes_expected} + 3'd1;
        cmd.off             = sequence_start;
        bytes_expected_next = 2'd0;
        bytes_taken_next    = 2'd0;
        partial_code_next   = '0;
      end else begin
        bytes_taken_next  = taken_inc[1:0];
        partial_code_next = gathered;
      end
    end else begin
      cmd.n_flush         = flush_cnt;
      bytes_expected_next = 2'd0;
      bytes_taken_next    = 2'd0;
      partial_code_next   = '0;
      priority if (text_byte[7] == 1'b0) begin
        cmd.act = udsd_pkg::ACT_CHAR;
        cmd.cp  = {13'd0, text_byte};
        cmd.len = 3'd1;
        cmd.off = next_offset;
      end else if (text_byte[7:5] == 3'b110) begin
        bytes_expected_next = 2'd1;
        partial_code_next   = {16'd0, text_byte[4:0]};
        sequence_start_next = next_offset;
      end else if (text_byte[7:4] == 4'b1110) begin
        bytes_expected_next = 2'd2;
        partial_code_next   = {17'd0, text_byte[3:0]};
        sequence_start_next = next_offset;
      end else if (text_byte[7:3] == 5'b11110) begin
        bytes_expected_next = 2'd3;
        partial_code_next   = {18'd0, text_byte[2:0]};
        sequence_start_next = next_offset;
      end else begin
        // stray continuation or F8-FF
        cmd.act = udsd_pkg::ACT_REPL;
        cmd.off = next_offset;
      end
    end
  end

  assign cmd_push = accept && ((cmd.n_flush != 2'd0) || (cmd.act != udsd_pkg::ACT_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_expected <= 2'd0;
      bytes_taken    <= 2'd0;
      partial_code   <= '0;
      sequence_start <= '0;
      next_offset    <= '0;
    end else if (accept) begin
      bytes_expected <= bytes_expected_next;
      bytes_taken    <= bytes_taken_next;
      partial_code   <= partial_code_next;
      sequence_start <= sequence_start_next;
      next_offset    <= next_offset_next;
    end
  end

endmodule

@@ sv/udsd_cmd_fifo.sv @@
// Short command queue between the front end and the result generator.
module udsd_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  udsd_pkg::cmd_t cmd_in,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output udsd_pkg::cmd_t cmd_out
);

  udsd_pkg::cmd_t                 mem [udsd_pkg::CMD_DEPTH];
  logic [udsd_pkg::CMD_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [udsd_pkg::CMD_PTR_BITS:0]   count;

  assign full    = (count == (udsd_pkg::CMD_PTR_BITS+1)'(udsd_pkg::CMD_DEPTH));
  assign empty   = (count == '0);
  assign cmd_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/udsd_back.sv @@
// Back end: expands command words into results, tracks script tallies, result queue.
module udsd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  udsd_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_pop,
  output logic           res_empty,
  output udsd_pkg::res_t res_head
);

  logic [1:0] idx, idx_next;
  logic       seen_han, seen_latin;
  logic [3:0] first_other_script;

  udsd_pkg::res_t res;
  udsd_pkg::res_t q [udsd_pkg::RES_DEPTH];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  logic       in_flush;
  logic       res_push;
  logic       pop_ok;
  logic [3:0] dom;
  logic [3:0] char_cls;

  assign in_flush = (idx < cmd.n_flush);
  assign char_cls = udsd_pkg::classify(cmd.cp);

  always_comb begin
    priority if (seen_han) begin
      dom = udsd_pkg::SCR_HAN;
    end else if (first_other_script != udsd_pkg::SCR_COMMON) begin
      dom = first_other_script;
    end else if (seen_latin) begin
      dom = udsd_pkg::SCR_LATIN;
    end else begin
      dom = udsd_pkg::SCR_COMMON;
    end
  end

  always_comb begin
    res = '0;
    if (in_flush) begin
      res.code_point  = udsd_pkg::REPL_CHAR;
      res.byte_length = 3'd1;
      res.byte_offset = 16'(cmd.flush_off + udsd_pkg::OFFSET_BITS'(idx));
      res.replaced    = 1'b1;
      res.last_of_run = ({1'b0, idx} + 3'd1 == {1'b0, cmd.n_flush}) &&
                        (cmd.act == udsd_pkg::ACT_NONE);
    end else begin
      res.last_of_run = 1'b1;
      unique case (cmd.act)
        udsd_pkg::ACT_CHAR: begin
          res.code_point   = cmd.cp;
          res.byte_length  = cmd.len;
          res.byte_offset  = 16'(cmd.off);
          res.script_class = char_cls;
        end
        udsd_pkg::ACT_REPL: begin
          res.code_point  = udsd_pkg::REPL_CHAR;
          res.byte_length = 3'd1;
          res.byte_offset = 16'(cmd.off);
          res.replaced    = 1'b1;
        end
        udsd_pkg::ACT_SUM: begin
          res.kind         = 1'b1;
          res.byte_offset  = 16'(cmd.off);
          res.script_class = dom;
        end
        default: begin
          res.script_class = udsd_pkg::SCR_COMMON;
        end
      endcase
    end
  end

  assign pop_ok    = res_pop && !res_empty;
  assign res_push  = cmd_valid && ((count != 2'(udsd_pkg::RES_DEPTH)) || pop_ok);
  assign cmd_pop   = res_push && res.last_of_run;
  assign idx_next  = cmd_pop ? 2'd0 : (res_push ? idx + 2'd1 : idx);
  assign res_empty = (count == 2'd0);
  assign res_head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_push) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx                <= 2'd0;
      seen_han           <= 1'b0;
      seen_latin         <= 1'b0;
      first_other_script <= udsd_pkg::SCR_COMMON;
      wr_ptr             <= 1'b0;
      rd_ptr             <= 1'b0;
      count              <= 2'd0;
    end else begin
      idx <= idx_next;
      if (res_push && !in_flush) begin
        if (cmd.act == udsd_pkg::ACT_SUM) begin
          seen_han           <= 1'b0;
          seen_latin         <= 1'b0;
          first_other_script <= udsd_pkg::SCR_COMMON;
        end else if (cmd.act == udsd_pkg::ACT_CHAR) begin
          if (char_cls == udsd_pkg::SCR_HAN) begin
            seen_han <= 1'b1;
          end else if (char_cls == udsd_pkg::SCR_LATIN) begin
            seen_latin <= 1'b1;
          end else if (char_cls != udsd_pkg::SCR_COMMON &&
                       first_other_script == udsd_pkg::SCR_COMMON) begin
            first_other_script <= char_cls;
          end
        end
      end
      if (res_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({res_push, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/utf8_decode_script_detect_core.sv @@
// Top level: streaming UTF-8 decoder with per-character script class and text summary.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-----------------------------------------
//  text    | in        | push / full        | text_byte
//  result  | out       | empty / pop        | kind, code_point, byte_length,
//          |           |                    | byte_offset, replaced, script_class,
//          |           |                    | last_of_run
//
// One byte is taken per cycle while the 4-deep command queue has room.
// The result generator emits one word per cycle while a command waits and the result
// queue has room; a byte that breaks a sequence or ends the text yields up to 3
// replacements plus at most one other word. Words pass through both queues; the 2-entry
// result queue keeps the generator running while a word waits for pop.
// rst is synchronous and clears decoder state, tallies and both queues.
module utf8_decode_script_detect_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [20:0] code_point,
  output logic [2:0]  byte_length,
  output logic [15:0] byte_offset,
  output logic        replaced,
  output logic [3:0]  script_class,
  output logic        last_of_run
);

  logic           accept;
  logic           cmd_push;
  logic           cmd_empty;
  logic           cmd_pop;
  udsd_pkg::cmd_t cmd_in;
  udsd_pkg::cmd_t cmd_head;
  udsd_pkg::res_t res_head;

  assign accept = push && !full;

  udsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (text_byte),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  udsd_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .cmd_in  (cmd_in),
    .full    (full),
    .pop     (cmd_pop),
    .empty   (cmd_empty),
    .cmd_out (cmd_head)
  );

  udsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res_head  (res_head)
  );

  assign kind         = res_head.kind;
  assign code_point   = res_head.code_point;
  assign byte_length  = res_head.byte_length;
  assign byte_offset  = res_head.byte_offset;
  assign replaced     = res_head.replaced;
  assign script_class = res_head.script_class;
  assign last_of_run  = res_head.last_of_run;

endmodule

@@ sv/udsd_checker.sv @@
// Port-level assertions for the decoder top level, with its bind.
module udsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        kind,
  input logic [20:0] code_point,
  input logic [2:0]  byte_length,
  input logic        replaced,
  input logic [3:0]  script_class,
  input logic        last_of_run
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_summary_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind) |-> (code_point == 21'd0 && byte_length == 3'd0 &&
                          !replaced && last_of_run))
    else $error("malformed summary word");

  a_repl_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && replaced) |-> (code_point == 21'h00FFFD && byte_length == 3'd1 &&
                              script_class == 4'd0 && !kind))
    else $error("malformed replacement word");

  a_char_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && !kind) |-> (byte_length >= 3'd1 && byte_length <= 3'd4))
    else $error("character word length out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(code_point) && $stable(kind)))
    else $error("waiting word changed before pop");

endmodule

bind utf8_decode_script_detect_core udsd_checker u_udsd_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .kind         (kind),
  .code_point   (code_point),
  .byte_length  (byte_length),
  .replaced     (replaced),
  .script_class (script_class),
  .last_of_run  (last_of_run)
);
